// ----- src/setm_pkg.sv -----
// ----------------------------------------------------------------------------
// setm_pkg: shared types and constants of the sorted expiry timer manager
// Opcodes, slot states, status codes and the cell control struct.
// ----------------------------------------------------------------------------
package setm_pkg;

	localparam int unsigned SLOTS_DEF     = 8;
	localparam int unsigned TICK_BITS_DEF = 32;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_CREATE = 3'd1;
	localparam logic [2:0] OP_START  = 3'd2;
	localparam logic [2:0] OP_STOP   = 3'd3;
	localparam logic [2:0] OP_DELETE = 3'd4;
	localparam logic [2:0] OP_QUERY  = 3'd5;
	localparam logic [2:0] OP_FETCH  = 3'd6;
	localparam logic [2:0] OP_NONE   = 3'd7;

	localparam logic [1:0] ST_INACTIVE = 2'd0;
	localparam logic [1:0] ST_STOPPED  = 2'd1;
	localparam logic [1:0] ST_RUNNING  = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_PARAM    = 2'd1;
	localparam logic [1:0] STS_NOTRUN   = 2'd2;

	// command broadcast to every queue cell
	typedef struct packed {
		logic rem;   // remove the entry whose slot matches
		logic ins;   // insert a new entry
	} cell_cmd_t;

endpackage

// ----- src/setm_cell.sv -----
// ----------------------------------------------------------------------------
// setm_cell: one entry of the sorted expiry queue
// Holds slot and expiry; shifts toward the head on remove, toward the tail
// on insert, or captures the new entry at the insert point.
// ----------------------------------------------------------------------------
module setm_cell #(
	parameter int unsigned SW = 3,
	parameter int unsigned TW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  setm_pkg::cell_cmd_t cmd,
	input  logic [SW-1:0]       key_slot,
	input  logic [TW-1:0]       key_when,
	input  logic                prev_valid,
	input  logic                prev_later,
	input  logic                prev_hit,
	input  logic [SW-1:0]       prev_slot,
	input  logic [TW-1:0]       prev_when,
	input  logic                next_valid,
	input  logic [SW-1:0]       next_slot,
	input  logic [TW-1:0]       next_when,
	output logic                valid,
	output logic                later,
	output logic                hit,
	output logic [SW-1:0]       slot_q,
	output logic [TW-1:0]       when_q
);
	import setm_pkg::*;

	logic          valid_q;
	logic [TW-1:0] diff;
	logic          take;

	assign valid = valid_q;
	assign diff  = key_when - when_q;
	// insert point is here or upstream (new entry sorts before this one,
	// equal goes behind)
	assign later = prev_later | (valid_q & diff[TW-1]);
	// this cell or one upstream holds the slot being removed
	assign hit   = prev_hit | (valid_q & (slot_q == key_slot));
	// shift or capture on insert: every cell at or past the insert point,
	// plus the first free cell
	assign take  = cmd.ins & prev_valid & (later | ~valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.rem && hit) begin
			valid_q <= next_valid;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rem && hit) begin
			slot_q <= next_slot;
			when_q <= next_when;
		end else if (take) begin
			if (prev_later) begin
				slot_q <= prev_slot;
				when_q <= prev_when;
			end else begin
				slot_q <= key_slot;
				when_q <= key_when;
			end
		end
	end

endmodule

// ----- src/sorted_expiry_timer_manager.sv -----
// ----------------------------------------------------------------------------
// sorted_expiry_timer_manager: timer slots with a sorted expiry queue
// One item is taken at a time; the cell chain removes at the accepting edge,
// inserts in the following S_INS state, and the result is then offered in
// S_OUT; out_stall holds the result there and keeps the input stalled.
// Reset: tick zero, queue empty, all slots inactive; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_manager #(
	parameter int unsigned SLOTS     = setm_pkg::SLOTS_DEF,
	parameter int unsigned TICK_BITS = setm_pkg::TICK_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [2:0]  slot,
	input  logic [31:0] ticks,
	input  logic        periodic,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        running,
	output logic        expired_valid,
	output logic [2:0]  expired_slot,
	output logic        expiry_pending
);
	import setm_pkg::*;

	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned TW = TICK_BITS;

	// one-hot sequencer: take item, run insert phase, present result
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_INS  = 3'b010,
		S_OUT  = 3'b100
	} fsm_t;

	fsm_t state_q;

	logic [TW-1:0] tick_q;
	logic [1:0]    sstate_q [SLOTS];
	logic          stype_q  [SLOTS];
	logic [TW-1:0] reload_q [SLOTS];

	// pending insert for the second phase
	logic          ins_q;
	logic [SW-1:0] ins_slot_q;
	logic [TW-1:0] ins_delay_q;

	logic [1:0] status_q;
	logic       running_q, exp_v_q;
	logic [2:0] exp_slot_q;

	// cell chain wiring
	cell_cmd_t     cmd;
	logic [SW-1:0] key_slot;
	logic [TW-1:0] key_when;
	logic          c_valid [SLOTS];
	logic          c_later [SLOTS];
	logic          c_hit   [SLOTS];
	logic [SW-1:0] c_slot  [SLOTS];
	logic [TW-1:0] c_when  [SLOTS];

	logic          take;
	logic          in_range, slot_ok;
	logic [SW-1:0] s_idx;
	logic [1:0]    cur_st;
	logic          head_due;
	logic [TW-1:0] head_diff;
	logic [SW-1:0] head_slot;
	logic          ins_need;

	assign take     = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	assign in_range = ({29'd0, slot} < 32'(SLOTS));
	assign s_idx    = SW'(slot);
	assign cur_st   = in_range ? sstate_q[s_idx] : ST_INACTIVE;
	assign slot_ok  = in_range && (cur_st != ST_INACTIVE);

	// head is due when its expiry is at or before the tick, wrap-safe
	assign head_diff = c_when[0] - tick_q;
	assign head_due  = c_valid[0] && (head_diff[TW-1] || (head_diff == '0));
	assign head_slot = c_slot[0];

	// a start with a good slot and delay, or a periodic fetch, queues again
	assign ins_need = ((op == OP_START) && slot_ok && (ticks != '0)) ||
		((op == OP_FETCH) && head_due && stype_q[head_slot]);

	// phase one removes, phase two inserts
	always_comb begin
		cmd      = '0;
		key_slot = ins_slot_q;
		key_when = tick_q + ins_delay_q;
		if (take) begin
			key_slot = (op == OP_FETCH) ? head_slot : s_idx;
			unique case (op)
				OP_CREATE: cmd.rem = in_range && (cur_st == ST_RUNNING);
				OP_START:  cmd.rem = slot_ok && (ticks != '0) && (cur_st == ST_RUNNING);
				OP_STOP:   cmd.rem = slot_ok && (cur_st == ST_RUNNING);
				OP_DELETE: cmd.rem = slot_ok && (cur_st == ST_RUNNING);
				OP_FETCH:  cmd.rem = head_due;
				default:   cmd.rem = 1'b0;
			endcase
		end else if (state_q == S_INS) begin
			cmd.ins = ins_q;
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic          pv, pl, ph, nv;
		logic [SW-1:0] ps, ns;
		logic [TW-1:0] pw, nw;
		if (i == 0) begin : g_first
			assign pv = 1'b1;
			assign pl = 1'b0;
			assign ph = 1'b0;
			assign ps = '0;
			assign pw = '0;
		end else begin : g_mid
			assign pv = c_valid[i-1];
			assign pl = c_later[i-1];
			assign ph = c_hit[i-1];
			assign ps = c_slot[i-1];
			assign pw = c_when[i-1];
		end
		if (i == SLOTS - 1) begin : g_last
			assign nv = 1'b0;
			assign ns = '0;
			assign nw = '0;
		end else begin : g_inner
			assign nv = c_valid[i+1];
			assign ns = c_slot[i+1];
			assign nw = c_when[i+1];
		end
		setm_cell #(.SW(SW), .TW(TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.key_slot(key_slot), .key_when(key_when),
			.prev_valid(pv), .prev_later(pl), .prev_hit(ph),
			.prev_slot(ps), .prev_when(pw),
			.next_valid(nv), .next_slot(ns), .next_when(nw),
			.valid(c_valid[i]), .later(c_later[i]), .hit(c_hit[i]),
			.slot_q(c_slot[i]), .when_q(c_when[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_q  <= '0;
			ins_q   <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				sstate_q[i] <= ST_INACTIVE;
				stype_q[i]  <= 1'b0;
				reload_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_INS;
						ins_q   <= ins_need;
						unique case (op)
							OP_TICK: tick_q <= tick_q + 1'b1;
							OP_CREATE: begin
								if (in_range) begin
									sstate_q[s_idx] <= ST_STOPPED;
									stype_q[s_idx]  <= periodic;
									reload_q[s_idx] <= '0;
								end
							end
							OP_START: begin
								// a restart keeps the old reload
								if (slot_ok && ticks != '0 && cur_st != ST_RUNNING) begin
									sstate_q[s_idx] <= ST_RUNNING;
									reload_q[s_idx] <= TW'({32'd0, ticks});
								end
							end
							OP_STOP: begin
								if (slot_ok && cur_st == ST_RUNNING)
									sstate_q[s_idx] <= ST_STOPPED;
							end
							OP_DELETE: begin
								if (slot_ok) sstate_q[s_idx] <= ST_INACTIVE;
							end
							OP_FETCH: begin
								if (head_due && !stype_q[head_slot])
									sstate_q[head_slot] <= ST_STOPPED;
							end
							default: ;
						endcase
					end
				end
				S_INS: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture the result fields and the insert payload with the item
	always_ff @(posedge clk) begin
		if (take) begin
			running_q  <= (op == OP_QUERY) && slot_ok && (cur_st == ST_RUNNING);
			exp_v_q    <= (op == OP_FETCH) && head_due;
			exp_slot_q <= ((op == OP_FETCH) && head_due) ? 3'(head_slot) : 3'd0;
			ins_slot_q <= (op == OP_FETCH) ? head_slot : s_idx;
			ins_delay_q <= (op == OP_FETCH) ? reload_q[head_slot] : TW'({32'd0, ticks});
			case (op) inside
				OP_TICK, OP_QUERY, OP_FETCH: status_q <= STS_OK;
				OP_CREATE: status_q <= in_range ? STS_OK : STS_PARAM;
				OP_START: status_q <= (!slot_ok || ticks == '0) ? STS_PARAM : STS_OK;
				OP_STOP: begin
					if (!slot_ok) status_q <= STS_PARAM;
					else if (cur_st != ST_RUNNING) status_q <= STS_NOTRUN;
					else status_q <= STS_OK;
				end
				OP_DELETE: status_q <= slot_ok ? STS_OK : STS_PARAM;
				default: status_q <= STS_PARAM;
			endcase
		end
	end

	assign out_valid      = (state_q == S_OUT);
	assign status         = status_q;
	assign running        = running_q;
	assign expired_valid  = exp_v_q;
	assign expired_slot   = exp_slot_q;
	assign expiry_pending = head_due;

endmodule

// ----- src/setm_checker.sv -----
// ----------------------------------------------------------------------------
// setm_checker: port-level checks of the timer manager
// Watches handshakes and result codes on the top level ports.
// ----------------------------------------------------------------------------
module setm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic       running,
	input logic       expired_valid,
	input logic [2:0] expired_slot
);
	import setm_pkg::*;

	// a result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");

	// no new item while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("item taken with result pending");

	// an accepted item gives a result once its insert phase is done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid) else $error("result missing");

	// fetch result carries a slot only when valid
	a_exp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !expired_valid |-> expired_slot == 3'd0)
		else $error("stray expired slot");

	// only a query reports running, and with ok status
	a_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running |-> status == STS_OK && !expired_valid)
		else $error("running with bad status");

endmodule

bind sorted_expiry_timer_manager setm_checker u_setm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.running(running), .expired_valid(expired_valid), .expired_slot(expired_slot)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted expiry timer manager
// Drives timer commands through the valid/stall input channel, predicts every
// result with a behavioral copy of the slot table and the sorted expiry queue,
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
	import setm_pkg::*;

	localparam int NSLOT = 8;

	typedef struct packed {
		logic [1:0] status;
		logic       running;
		logic       expired_valid;
		logic [2:0] expired_slot;
		logic       expiry_pending;
	} timer_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = OP_TICK;
	logic [2:0]  slot = '0;
	logic [31:0] ticks = '0;
	logic        periodic = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        running;
	logic        expired_valid;
	logic [2:0]  expired_slot;
	logic        expiry_pending;

	sorted_expiry_timer_manager u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slot(slot), .ticks(ticks), .periodic(periodic),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.running(running), .expired_valid(expired_valid),
		.expired_slot(expired_slot), .expiry_pending(expiry_pending)
	);

	always #2 clk = ~clk;

	// predicted timer state
	logic [31:0] now_tick;
	logic [2:0]  q_slot [NSLOT];
	logic [31:0] q_when [NSLOT];
	int          q_len;
	logic [1:0]  slot_st [NSLOT];
	logic        slot_per [NSLOT];
	logic [31:0] slot_rel [NSLOT];

	timer_result_t pending_results[$];
	int  fail_count = 0;
	bit  idle_in = 1'b1;     // random idling allowed on the sender
	bit  idle_out = 1'b1;    // random stalls allowed on the receiver
	int  hold_cycles = 0;    // long receiver hold-off, counted below

	function automatic bit earlier(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic void queue_drop(logic [2:0] s);
		for (int i = 0; i < q_len; i++)
			if (q_slot[i] == s) begin
				for (int j = i; j + 1 < q_len; j++) begin
					q_slot[j] = q_slot[j + 1];
					q_when[j] = q_when[j + 1];
				end
				q_len--;
				return;
			end
	endfunction

	function automatic void queue_add(logic [2:0] s, logic [31:0] delay);
		logic [31:0] w;
		int pos;
		w = now_tick + delay;
		pos = 0;
		if (q_len >= NSLOT)
			return;
		while (pos < q_len && !earlier(w, q_when[pos]))
			pos++;
		for (int j = q_len; j > pos; j--) begin
			q_slot[j] = q_slot[j - 1];
			q_when[j] = q_when[j - 1];
		end
		q_slot[pos] = s;
		q_when[pos] = w;
		q_len++;
	endfunction

	function automatic bit head_due();
		return q_len > 0 && (earlier(q_when[0], now_tick) || q_when[0] == now_tick);
	endfunction

	// apply one command to the predicted state and return its result
	function automatic timer_result_t timer_apply(logic [2:0] o, logic [2:0] s,
			logic [31:0] t, logic p);
		timer_result_t r;
		bit created;
		logic [2:0] h;
		r = '0;
		created = slot_st[s] != ST_INACTIVE;
		case (o)
			OP_TICK: now_tick++;
			OP_CREATE: begin
				if (slot_st[s] == ST_RUNNING)
					queue_drop(s);
				slot_st[s] = ST_STOPPED;
				slot_per[s] = p;
				slot_rel[s] = '0;
			end
			OP_START: begin
				if (!created || t == 0) begin
					r.status = STS_PARAM;
				end else begin
					if (slot_st[s] == ST_RUNNING) begin
						queue_drop(s);
					end else begin
						slot_st[s] = ST_RUNNING;
						slot_rel[s] = t;
					end
					queue_add(s, t);
				end
			end
			OP_STOP: begin
				if (!created) r.status = STS_PARAM;
				else if (slot_st[s] != ST_RUNNING) r.status = STS_NOTRUN;
				else begin
					slot_st[s] = ST_STOPPED;
					queue_drop(s);
				end
			end
			OP_DELETE: begin
				if (!created) begin
					r.status = STS_PARAM;
				end else begin
					if (slot_st[s] == ST_RUNNING)
						queue_drop(s);
					slot_st[s] = ST_INACTIVE;
				end
			end
			OP_QUERY: r.running = slot_st[s] == ST_RUNNING;
			OP_FETCH: begin
				if (head_due()) begin
					h = q_slot[0];
					queue_drop(h);
					if (slot_per[h])
						queue_add(h, slot_rel[h]);
					else
						slot_st[h] = ST_STOPPED;
					r.expired_valid = 1'b1;
					r.expired_slot = h;
				end
			end
			default: r.status = STS_PARAM;
		endcase
		r.expiry_pending = head_due();
		return r;
	endfunction

	// send one item from the next falling edge; hold it until accepted, then
	// predict it; the caller drops valid once no item follows
	task automatic send_cmd(logic [2:0] o, logic [2:0] s, logic [31:0] t, logic p);
		@(negedge clk);
		while (idle_in && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		slot <= s;
		ticks <= t;
		periodic <= p;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(timer_apply(o, s, t, p));
	endtask

	// receiver stall: random, or held for a long stretch on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= idle_out && ($urandom_range(99) < 35);
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no item waiting");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, status);
					fail_count++;
				end
				if (running !== want.running) begin
					$error("running: expected %0d actual %0d", want.running, running);
					fail_count++;
				end
				if (expired_valid !== want.expired_valid) begin
					$error("expired_valid: expected %0d actual %0d",
						want.expired_valid, expired_valid);
					fail_count++;
				end
				if (expired_slot !== want.expired_slot) begin
					$error("expired_slot: expected %0d actual %0d",
						want.expired_slot, expired_slot);
					fail_count++;
				end
				if (expiry_pending !== want.expiry_pending) begin
					$error("expiry_pending: expected %0d actual %0d",
						want.expiry_pending, expiry_pending);
					fail_count++;
				end
			end
		end
	end

	task automatic tick_n(int n);
		for (int i = 0; i < n; i++)
			send_cmd(OP_TICK, 3'($urandom), $urandom, 1'($urandom));
	endtask

	// extremes, every op and the corner cases below
	task automatic test_directed();
		send_cmd(OP_START, 3'd0, 32'd5, 1'b0);           // start on uncreated slot
		send_cmd(OP_STOP, 3'd1, 32'd0, 1'b0);            // stop on uncreated slot
		send_cmd(OP_DELETE, 3'd7, 32'd0, 1'b0);          // delete on uncreated slot
		send_cmd(OP_FETCH, 3'd0, 32'd0, 1'b0);           // fetch on empty queue
		send_cmd(OP_CREATE, 3'd0, 32'hFFFF_FFFF, 1'b1);
		send_cmd(OP_CREATE, 3'd7, 32'd0, 1'b0);
		send_cmd(OP_START, 3'd0, 32'd0, 1'b0);           // zero delay
		send_cmd(OP_STOP, 3'd0, 32'd0, 1'b0);            // stop of stopped timer
		send_cmd(OP_START, 3'd0, 32'd2, 1'b0);
		send_cmd(OP_START, 3'd7, 32'd2, 1'b1);           // equal expiry, queues behind
		send_cmd(OP_QUERY, 3'd0, 32'd0, 1'b0);
		send_cmd(OP_START, 3'd0, 32'd1, 1'b0);           // restart keeps old reload
		tick_n(2);
		send_cmd(OP_FETCH, 3'd0, 32'd0, 1'b0);           // periodic requeue
		send_cmd(OP_FETCH, 3'd0, 32'd0, 1'b0);           // one-shot stops
		send_cmd(OP_FETCH, 3'd0, 32'd0, 1'b0);
		send_cmd(OP_CREATE, 3'd0, 32'd0, 1'b0);          // create on running slot
		send_cmd(OP_START, 3'd7, 32'hFFFF_FFFF, 1'b0);   // wrap-around expiry
		send_cmd(OP_DELETE, 3'd7, 32'd0, 1'b0);
		send_cmd(OP_QUERY, 3'd7, 32'd0, 1'b0);
		send_cmd(OP_NONE, 3'd5, 32'hA5A5_5A5A, 1'b1);    // unknown op
	endtask

	// mostly create/start/tick/fetch traffic with short delays
	task automatic test_random(int n);
		logic [2:0] o;
		logic [31:0] t;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 25) o = OP_TICK;
			else if (r < 35) o = OP_CREATE;
			else if (r < 55) o = OP_START;
			else if (r < 62) o = OP_STOP;
			else if (r < 67) o = OP_DELETE;
			else if (r < 75) o = OP_QUERY;
			else if (r < 98) o = OP_FETCH;
			else o = OP_NONE;
			r = $urandom_range(99);
			if (r < 5) t = 32'd0;
			else if (r < 15) t = $urandom;
			else if (r < 20) t = 32'hFFFF_FFFF - $urandom_range(3);
			else t = $urandom_range(1, 8);
			send_cmd(o, 3'($urandom), t, 1'($urandom));
		end
	endtask

	// no idling at all on either side
	task automatic test_full_rate();
		idle_in = 1'b0;
		idle_out = 1'b0;
		test_random(150);
		idle_in = 1'b1;
		idle_out = 1'b1;
	endtask

	// hold the receiver off long enough to fill the block and stall its input
	task automatic test_backpressure();
		idle_in = 1'b0;
		@(negedge clk);
		hold_cycles = 60;
		test_random(20);
		idle_in = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		now_tick = '0;
		q_len = 0;
		for (int i = 0; i < NSLOT; i++) begin
			slot_st[i] = ST_INACTIVE;
			slot_per[i] = 1'b0;
			slot_rel[i] = '0;
		end
		test_directed();
		test_random(400);
		test_backpressure();
		test_full_rate();
		test_random(400);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_expiry_timer_manager test passed");
		else
			$display("sorted_expiry_timer_manager test failed");
		$finish;
	end

	initial begin
		#400000;
		$display("sorted_expiry_timer_manager test failed");
		$finish;
	end

endmodule
